@@ rtl/ksx_pkg.sv @@
// ksx_pkg: shared types and constants for the spin exchange step block
// used by kawasaki_spin_exchange_step and its port checker, no dependencies
`default_nettype none

package ksx_pkg;

  localparam int unsigned GRID_X_DEF  = 64;
  localparam int unsigned GRID_Y_DEF  = 64;

  localparam int unsigned NUM_CLASSES = 7;
  localparam int unsigned THR_W       = 17;
  localparam logic [THR_W-1:0] THR_RESET = 17'h10000;

  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned IN_DATA_W   = 32;
  localparam int unsigned OUT_DATA_W  = 8;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACCEPT_M6,
    CFG_ACCEPT_M4,
    CFG_ACCEPT_M2,
    CFG_ACCEPT_ZERO,
    CFG_ACCEPT_P2,
    CFG_ACCEPT_P4,
    CFG_ACCEPT_P6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OUT_SWAPPED,
    OUT_REJECTED,
    OUT_SKIPPED,
    OUT_RESET
  } outcome_e;

  typedef enum logic [1:0] {
    DIR_XP,
    DIR_XM,
    DIR_YP,
    DIR_YM
  } dir_e;

endpackage

`default_nettype wire

@@ rtl/kawasaki_spin_exchange_step.sv @@
// kawasaki_spin_exchange_step: spin exchange metropolis step on a 2d lattice
// depends on ksx_pkg; lattice rows held in four row-interleaved banks
//
// channel   direction  handshake                   payload
// s_axis    in         s_axis_tvalid/tready        tuser: mode, tdata: move
// m_axis    out        m_axis_tvalid/tready        tdata: outcome, class
// cfg       in         cfg_valid_i/cfg_ready_o     cfg_index_i, cfg_data_i
//
// one transfer in per cycle unless the output stalls; each item is held in
// stage 1 with the registered read of the four lattice row banks, then in
// the result register; reset clears per-row valid bits, so the lattice is
// usable at once; a lattice reset item clears them as it leaves stage 1
// a stalled output holds the result; input is taken while the stage behind
// can move on
`default_nettype none

module kawasaki_spin_exchange_step
  import ksx_pkg::*;
#(
  parameter int unsigned GRID_X = GRID_X_DEF,
  parameter int unsigned GRID_Y = GRID_Y_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [5:0] site_x, [11:6] site_y, [13:12] direction, [29:14] uniform
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // [0] mode
  input  logic                  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [1:0] outcome, [4:2] energy_class
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [THR_W-1:0]      cfg_data_i
);

  localparam int unsigned XW     = (GRID_X > 1) ? $clog2(GRID_X) : 1;
  localparam int unsigned RW     = $clog2(GRID_Y);
  localparam int unsigned YW     = ((RW > 6) ? RW : 6) + 1;
  localparam int unsigned BD     = (GRID_Y + 3) / 4;
  localparam int unsigned BAW    = (BD > 1) ? $clog2(BD) : 1;
  localparam int unsigned HALF_Y = GRID_Y / 2;

  // handshake
  logic in_fire, adv, lat_clr;
  logic s1_valid_q, s1_valid_d;
  logic m_valid_q, m_valid_d;

  // input fields
  logic [5:0]    in_x, in_y;
  logic [1:0]    in_dir;
  logic [YW-1:0] in_ylo, in_base;

  // stage 1 item
  logic          s1_mode_q;
  logic [5:0]    s1_x_q, s1_y_q;
  logic [1:0]    s1_dir_q;
  logic [15:0]   s1_u_q;
  logic [YW-1:0] s1_base_q;

  // banks
  logic [BAW-1:0]    rd_addr   [4];
  logic [GRID_X-1:0] rd_data_q [4];
  logic [3:0]        rd_vld_q;
  logic [BD-1:0]     vld_q     [4];
  logic [3:0]        wr_en;
  logic [BAW-1:0]    wr_addr   [4];
  logic [GRID_X-1:0] wr_data   [4];

  // stage 1 evaluation
  logic [GRID_X-1:0] row_w    [4];
  logic [1:0]        bank_sel [4];
  logic [YW-1:0]     row_num  [4];
  logic [XW-1:0]     xa, xp, xm, xp2, xm2, xb, xao, xbo;
  logic              vert, x_ok, y_ok, wall, sa, sb;
  logic [1:0]        c1, c2;
  logic [2:0]        cls;
  logic              evaluated, accepted, swap;
  logic [GRID_X-1:0] new1, new2, bit_a, bit_b;
  logic [YW-1:0]     ylo;

  // config and result
  logic [THR_W-1:0] thr_q [NUM_CLASSES];
  outcome_e         m_outcome_q, m_outcome_d;
  logic [2:0]       m_cls_q, m_cls_d;

  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign adv           = s1_valid_q && (!m_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || adv;
  assign lat_clr       = adv && s1_mode_q;

  assign in_x   = s_axis_tdata[5:0];
  assign in_y   = s_axis_tdata[11:6];
  assign in_dir = s_axis_tdata[13:12];

  // a move downward is the same exchange as a move up from the row below,
  // so rows ylo-1 .. ylo+2 cover every case
  assign in_ylo  = (in_dir == DIR_YM) ? YW'(in_y) - YW'(1) : YW'(in_y);
  assign in_base = in_ylo - YW'(1);

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_mode_q <= s_axis_tuser;
      s1_x_q    <= in_x;
      s1_y_q    <= in_y;
      s1_dir_q  <= in_dir;
      s1_u_q    <= s_axis_tdata[29:14];
      s1_base_q <= in_base;
    end
  end

  // four banks, bank b holds rows with row mod 4 == b
  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [GRID_X-1:0] mem_q [BD];
    logic [1:0]        rd_off;
    logic [YW-1:0]     rd_row;
    logic              wr_hit;

    assign rd_off     = 2'(b) - in_base[1:0];
    assign rd_row     = in_base + YW'(rd_off);
    assign rd_addr[b] = rd_row[BAW+1:2];
    // a write in the same cycle is forwarded to the read
    assign wr_hit     = wr_en[b] && (wr_addr[b] == rd_addr[b]);

    always_ff @(posedge clk_i) begin
      if (wr_en[b]) begin
        mem_q[wr_addr[b]] <= wr_data[b];
      end
    end

    always_ff @(posedge clk_i) begin
      if (in_fire) begin
        rd_data_q[b] <= wr_hit ? wr_data[b] : mem_q[rd_addr[b]];
        rd_vld_q[b]  <= !lat_clr && (wr_hit || vld_q[b][rd_addr[b]]);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[b] <= '0;
      end else if (lat_clr) begin
        vld_q[b] <= '0;
      end else if (wr_en[b]) begin
        vld_q[b][wr_addr[b]] <= 1'b1;
      end
    end
  end

  // rows ylo-1 .. ylo+2 of the item in stage 1; unwritten rows read as start
  for (genvar k = 0; k < 4; k++) begin : g_row
    assign bank_sel[k] = s1_base_q[1:0] + 2'(k);
    assign row_num[k]  = s1_base_q + YW'(k);
    assign row_w[k]    = rd_vld_q[bank_sel[k]] ? rd_data_q[bank_sel[k]]
                       : ((row_num[k] < YW'(HALF_Y)) ? '0 : '1);
  end

  assign xa   = s1_x_q[XW-1:0];
  assign xp   = (xa == XW'(GRID_X - 1)) ? '0 : xa + XW'(1);
  assign xm   = (xa == '0) ? XW'(GRID_X - 1) : xa - XW'(1);
  assign xp2  = (xp == XW'(GRID_X - 1)) ? '0 : xp + XW'(1);
  assign xm2  = (xm == '0) ? XW'(GRID_X - 1) : xm - XW'(1);
  assign vert = (s1_dir_q == DIR_YP) || (s1_dir_q == DIR_YM);
  assign xb   = (s1_dir_q == DIR_XP) ? xp : xm;
  assign xao  = (s1_dir_q == DIR_XP) ? xm : xp;
  assign xbo  = (s1_dir_q == DIR_XP) ? xp2 : xm2;
  assign ylo  = s1_base_q + YW'(1);

  assign x_ok = {1'b0, s1_x_q} < 7'(GRID_X);
  assign y_ok = (YW'(s1_y_q) >= YW'(1)) && (YW'(s1_y_q) <= YW'(GRID_Y - 2));
  assign wall = vert && ((ylo == '0) || (ylo == YW'(GRID_Y - 2)));

  assign sa = row_w[1][xa];
  assign sb = vert ? row_w[2][xa] : row_w[1][xb];

  // up-spin counts among the three outer neighbors of each site
  always_comb begin
    if (vert) begin
      c1 = 2'({1'b0, row_w[1][xp]} + {1'b0, row_w[1][xm]} + {1'b0, row_w[0][xa]});
      c2 = 2'({1'b0, row_w[2][xp]} + {1'b0, row_w[2][xm]} + {1'b0, row_w[3][xa]});
    end else begin
      c1 = 2'({1'b0, row_w[1][xao]} + {1'b0, row_w[0][xa]} + {1'b0, row_w[2][xa]});
      c2 = 2'({1'b0, row_w[1][xbo]} + {1'b0, row_w[0][xb]} + {1'b0, row_w[2][xb]});
    end
  end

  // class = (d+6)/2 with d = s1*(h1-h2) and h = 2*count-3
  assign cls = sa ? 3'd3 + {1'b0, c1} - {1'b0, c2}
                  : 3'd3 - {1'b0, c1} + {1'b0, c2};

  assign evaluated = !s1_mode_q && x_ok && y_ok && !wall && (sa != sb);
  assign accepted  = {1'b0, s1_u_q} < thr_q[cls];
  assign swap      = evaluated && accepted;

  assign bit_a = GRID_X'(1) << xa;
  assign bit_b = GRID_X'(1) << xb;
  assign new1  = row_w[1] ^ (vert ? bit_a : (bit_a | bit_b));
  assign new2  = row_w[2] ^ bit_a;

  for (genvar b = 0; b < 4; b++) begin : g_wr
    assign wr_en[b]   = adv && swap
                     && ((bank_sel[1] == 2'(b)) || (vert && (bank_sel[2] == 2'(b))));
    assign wr_addr[b] = (bank_sel[1] == 2'(b)) ? row_num[1][BAW+1:2] : row_num[2][BAW+1:2];
    assign wr_data[b] = (bank_sel[1] == 2'(b)) ? new1 : new2;
  end

  // result register
  always_comb begin
    m_valid_d   = m_valid_q;
    m_outcome_d = m_outcome_q;
    m_cls_d     = m_cls_q;
    if (adv) begin
      m_valid_d = 1'b1;
      m_cls_d   = evaluated ? cls : 3'd0;
      priority if (s1_mode_q) begin
        m_outcome_d = OUT_RESET;
      end else if (!evaluated) begin
        m_outcome_d = OUT_SKIPPED;
      end else if (swap) begin
        m_outcome_d = OUT_SWAPPED;
      end else begin
        m_outcome_d = OUT_REJECTED;
      end
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_outcome_q <= m_outcome_d;
    m_cls_q     <= m_cls_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {3'b000, m_cls_q, m_outcome_q};

  // acceptance thresholds
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        thr_q[i] <= THR_RESET;
      end
    end else if (cfg_valid_i && (cfg_index_i <= CFG_ACCEPT_P6)) begin
      thr_q[cfg_index_i] <= cfg_data_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/ksx_checker.sv @@
// ksx_checker: port-level assertions for kawasaki_spin_exchange_step
// depends on ksx_pkg; bound to the top level at the end of this file
`default_nettype none

module ksx_checker
  import ksx_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result payload changed while stalled");

  // skipped moves and lattice resets carry no energy class
  a_class_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && ((m_axis_tdata[1:0] == OUT_SKIPPED) || (m_axis_tdata[1:0] == OUT_RESET))
    |-> (m_axis_tdata[4:2] == 3'd0))
    else $error("energy class set on a skipped or reset result");

  // input side only backs up when the output is held by the consumer
  a_in_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled while output is free");

endmodule

bind kawasaki_spin_exchange_step ksx_checker u_ksx_checker (.*);

`default_nettype wire
